// ===== hw/rtl/cgsd_pkg.sv =====
// Types, constants and the glyph font shared by the serial glyph driver.
`timescale 1ns / 1ps
`default_nettype none
package cgsd_pkg;

  localparam int unsigned BitsPerColumn   = 8;
  localparam int unsigned FontColumns     = 5;
  localparam int unsigned FontBits        = FontColumns * BitsPerColumn;
  localparam int unsigned ColumnsPerGlyph = 5;
  localparam int unsigned QueueDepth      = 2;
  localparam int unsigned OpWidth         = 2;
  localparam int unsigned KindWidth       = 2;
  localparam int unsigned CharWidth       = 8;

  typedef enum logic [OpWidth-1:0] {
    OpOpen  = 2'd0,
    OpChar  = 2'd1,
    OpClose = 2'd2
  } cgsd_op_e;

  typedef enum logic [KindWidth-1:0] {
    KindBit   = 2'd0,
    KindStart = 2'd1,
    KindEnd   = 2'd2
  } cgsd_kind_e;

  localparam logic [FontBits-1:0] GlyphX = 40'h6314081463;

  // Column 0 in the top byte, each column MSB first.
  function automatic logic [FontBits-1:0] font_lookup(input logic [CharWidth-1:0] code);
    logic [FontBits-1:0] g;
    unique case (code)
      8'h20:   g = 40'h0000000000;
      8'h41:   g = 40'h7E0909097E;
      8'h42:   g = 40'h7F49494976;
      8'h43:   g = 40'h3E41414122;
      8'h44:   g = 40'h7F4141417E;
      8'h45:   g = 40'h7F49494941;
      8'h46:   g = 40'h7F09090901;
      8'h47:   g = 40'h7E41494939;
      8'h48:   g = 40'h7F0808087F;
      8'h49:   g = 40'h00417F4100;
      8'h4A:   g = 40'h002040407F;
      8'h4B:   g = 40'h7F08142241;
      8'h4C:   g = 40'h7F40404040;
      8'h4D:   g = 40'h7F0204027F;
      8'h4E:   g = 40'h7F0408107F;
      8'h4F:   g = 40'h3E4141413E;
      8'h50:   g = 40'h7F09090907;
      8'h51:   g = 40'h3E4151617E;
      8'h52:   g = 40'h7F09192946;
      8'h53:   g = 40'h4F49494979;
      8'h54:   g = 40'h01017F0101;
      8'h55:   g = 40'h3F4040403F;
      8'h56:   g = 40'h1F2040201F;
      8'h57:   g = 40'h3F4030403F;
      8'h59:   g = 40'h070878080F & 40'hFFFFFFFFF7;
      8'h5A:   g = 40'h6151494543;
      8'h30:   g = 40'h3E4141413E;
      8'h31:   g = 40'h000004027F;
      8'h32:   g = 40'h4661514946;
      8'h33:   g = 40'h2241494936;
      8'h34:   g = 40'h1814127F10;
      8'h35:   g = 40'h2745454539;
      8'h36:   g = 40'h3E49494932;
      8'h37:   g = 40'h0101790503;
      8'h38:   g = 40'h3649494936;
      8'h39:   g = 40'h064949493E;
      8'h3D:   g = 40'h2424242424;
      8'h2E:   g = 40'h0060600000;
      8'h3A:   g = 40'h0066660000;
      8'h3E:   g = 40'h0041221408;
      8'h3C:   g = 40'h0814224100;
      8'h2F:   g = 40'h2010080402;
      8'h21:   g = 40'h00005F0000;
      8'h7C:   g = 40'h00007F0000;
      default: g = GlyphX;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cgsd_if.sv =====
// Valid/ready channel interfaces for command items and serial result items.
`timescale 1ns / 1ps
`default_nettype none
interface cgsd_in_if;
  logic                             valid;
  logic                             ready;
  logic [cgsd_pkg::OpWidth-1:0]     operation;
  logic [cgsd_pkg::CharWidth-1:0]   character;

  modport source (output valid, output operation, output character, input ready);
  modport sink   (input valid, input operation, input character, output ready);
endinterface

interface cgsd_out_if;
  logic                             valid;
  logic                             ready;
  logic [cgsd_pkg::KindWidth-1:0]   kind;
  logic                             data_bit;
  logic                             register_select;
  logic                             last;

  modport source (output valid, output kind, output data_bit, output register_select,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_bit, input register_select,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/char_glyph_serial_driver_top.sv =====
// A command item is stored in the queue register; its first result item is then registered
// in the output register. A character item yields COLUMNS_PER_GLYPH * 8 bit items, one bit
// per cycle from the back-end shift register while the output is ready; open and close items yield one item each.
// A two-entry queue lets new items be accepted while a glyph is still shifting.
// Reset (asynchronous, active low) empties the queue and clears the output valid.
`timescale 1ns / 1ps
`default_nettype none
module char_glyph_serial_driver_top #(
  parameter int unsigned COLUMNS_PER_GLYPH = cgsd_pkg::ColumnsPerGlyph
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cgsd_in_if.sink     in_i,
  cgsd_out_if.source  out_o
);

  localparam int unsigned GlyphBits = COLUMNS_PER_GLYPH * cgsd_pkg::BitsPerColumn;
  localparam int unsigned EntryW    = cgsd_pkg::OpWidth + GlyphBits;

  logic              q_full, q_push, q_pop, q_valid;
  logic [EntryW-1:0] q_wdata, q_rdata;

  cgsd_front #(.GlyphBits(GlyphBits)) u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  cgsd_queue #(.Width(EntryW), .Depth(cgsd_pkg::QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  cgsd_back #(.GlyphBits(GlyphBits)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/cgsd_front.sv =====
// Front end: accepts command items, drops reserved ones, looks up glyphs.
`timescale 1ns / 1ps
`default_nettype none
module cgsd_front #(
  parameter int unsigned GlyphBits = cgsd_pkg::FontBits
) (
  cgsd_in_if.sink                               in_i,
  input  logic                                  q_full_i,
  output logic                                  q_push_o,
  output logic [cgsd_pkg::OpWidth+GlyphBits-1:0] q_data_o
);

  logic [cgsd_pkg::FontBits-1:0] font;
  logic [GlyphBits-1:0]          glyph;
  logic                          known_op;

  assign in_i.ready = !q_full_i;

  always_comb begin
    font  = cgsd_pkg::font_lookup(in_i.character);
    glyph = '0;
    glyph[GlyphBits-1 -: cgsd_pkg::FontBits] = font;
  end

  assign known_op = (in_i.operation == cgsd_pkg::OpOpen)
                 || (in_i.operation == cgsd_pkg::OpChar)
                 || (in_i.operation == cgsd_pkg::OpClose);

  assign q_push_o = in_i.valid && !q_full_i && known_op;
  assign q_data_o = {in_i.operation, glyph};

endmodule
`default_nettype wire

// ===== hw/rtl/cgsd_queue.sv =====
// Short register queue between the front end and the shift engine.
`timescale 1ns / 1ps
`default_nettype none
module cgsd_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = cgsd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cgsd_back.sv =====
// Back end: shifts glyph bits out and emits frame start and frame end items.
`timescale 1ns / 1ps
`default_nettype none
module cgsd_back #(
  parameter int unsigned GlyphBits = cgsd_pkg::FontBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  input  logic [cgsd_pkg::OpWidth+GlyphBits-1:0] q_data_i,
  output logic                                   q_pop_o,
  cgsd_out_if.source                             out_o
);

  localparam int unsigned RemW = $clog2(GlyphBits);

  cgsd_pkg::cgsd_op_e          op;
  logic [GlyphBits-1:0]        glyph;
  logic                        out_load;

  logic                        vld_q, vld_d;
  cgsd_pkg::cgsd_kind_e        kind_q, kind_d;
  logic                        bit_q, bit_d;
  logic                        last_q, last_d;
  logic [GlyphBits-1:0]        shift_q, shift_d;
  logic [RemW-1:0]             rem_q, rem_d;

  assign op       = cgsd_pkg::cgsd_op_e'(q_data_i[cgsd_pkg::OpWidth+GlyphBits-1 -: cgsd_pkg::OpWidth]);
  assign glyph    = q_data_i[GlyphBits-1:0];
  assign out_load = !vld_q || out_o.ready;

  always_comb begin
    vld_d   = vld_q;
    kind_d  = kind_q;
    bit_d   = bit_q;
    last_d  = last_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    q_pop_o = 1'b0;
    if (out_load) begin
      if (rem_q != '0) begin
        vld_d   = 1'b1;
        kind_d  = cgsd_pkg::KindBit;
        bit_d   = shift_q[GlyphBits-1];
        shift_d = shift_q << 1;
        rem_d   = rem_q - 1'b1;
        last_d  = (rem_q == RemW'(1));
      end else if (q_valid_i) begin
        q_pop_o = 1'b1;
        vld_d   = 1'b1;
        bit_d   = 1'b0;
        last_d  = 1'b1;
        unique case (op)
          cgsd_pkg::OpChar: begin
            kind_d  = cgsd_pkg::KindBit;
            bit_d   = glyph[GlyphBits-1];
            shift_d = glyph << 1;
            rem_d   = RemW'(GlyphBits - 1);
            last_d  = 1'b0;
          end
          cgsd_pkg::OpOpen:  kind_d = cgsd_pkg::KindStart;
          cgsd_pkg::OpClose: kind_d = cgsd_pkg::KindEnd;
          default:           vld_d  = 1'b0;
        endcase
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= '0;
    end else begin
      vld_q <= vld_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    bit_q   <= bit_d;
    last_q  <= last_d;
    shift_q <= shift_d;
  end

  assign out_o.valid           = vld_q;
  assign out_o.kind            = kind_q;
  assign out_o.data_bit        = bit_q;
  assign out_o.register_select = 1'b0;
  assign out_o.last            = last_q;

endmodule
`default_nettype wire

// ===== tb/char_glyph_serial_driver_top_tb.sv =====
// Testbench for char_glyph_serial_driver_top: random frames of glyph commands, predicted pulses.
`timescale 1ns / 1ps
module char_glyph_serial_driver_top_tb;
  import cgsd_pkg::*;

  localparam int unsigned GlyphCols   = ColumnsPerGlyph;
  localparam int unsigned TargetItems = 230;
  localparam int unsigned RunLimitNs  = 2_000_000;
  localparam int unsigned IdlePct     = 13;
  localparam logic [OpWidth-1:0] OpReserved = 2'd3;

  class glyph_scoreboard;
    typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic                 data_bit;
      logic                 reg_sel;
      logic                 last;
    } pulse_t;

    pulse_t      pulse_q[$];
    int unsigned mismatches;
    int unsigned columns;

    function new(int unsigned cols);
      columns    = cols;
      mismatches = 0;
    endfunction

    function logic [FontBits-1:0] glyph_bits(logic [CharWidth-1:0] code);
      case (code)
        " ":     return 40'h0000000000;
        "A":     return 40'h7E0909097E;
        "B":     return 40'h7F49494976;
        "C":     return 40'h3E41414122;
        "D":     return 40'h7F4141417E;
        "E":     return 40'h7F49494941;
        "F":     return 40'h7F09090901;
        "G":     return 40'h7E41494939;
        "H":     return 40'h7F0808087F;
        "I":     return 40'h00417F4100;
        "J":     return 40'h002040407F;
        "K":     return 40'h7F08142241;
        "L":     return 40'h7F40404040;
        "M":     return 40'h7F0204027F;
        "N":     return 40'h7F0408107F;
        "O":     return 40'h3E4141413E;
        "P":     return 40'h7F09090907;
        "Q":     return 40'h3E4151617E;
        "R":     return 40'h7F09192946;
        "S":     return 40'h4F49494979;
        "T":     return 40'h01017F0101;
        "U":     return 40'h3F4040403F;
        "V":     return 40'h1F2040201F;
        "W":     return 40'h3F4030403F;
        "Y":     return 40'h0708780807;
        "Z":     return 40'h6151494543;
        "0":     return 40'h3E4141413E;
        "1":     return 40'h000004027F;
        "2":     return 40'h4661514946;
        "3":     return 40'h2241494936;
        "4":     return 40'h1814127F10;
        "5":     return 40'h2745454539;
        "6":     return 40'h3E49494932;
        "7":     return 40'h0101790503;
        "8":     return 40'h3649494936;
        "9":     return 40'h064949493E;
        "=":     return 40'h2424242424;
        ".":     return 40'h0060600000;
        ":":     return 40'h0066660000;
        ">":     return 40'h0041221408;
        "<":     return 40'h0814224100;
        "/":     return 40'h2010080402;
        "!":     return 40'h00005F0000;
        "|":     return 40'h00007F0000;
        default: return 40'h6314081463;
      endcase
    endfunction

    function void note_cmd(logic [OpWidth-1:0] op, logic [CharWidth-1:0] code);
      logic [FontBits-1:0] glyph;
      pulse_t              p;
      int unsigned         total;
      total = columns * BitsPerColumn;
      glyph = glyph_bits(code);
      case (op)
        OpOpen: begin
          p = '{KindStart, 1'b0, 1'b0, 1'b1};
          pulse_q.push_back(p);
        end
        OpClose: begin
          p = '{KindEnd, 1'b0, 1'b0, 1'b1};
          pulse_q.push_back(p);
        end
        OpChar: begin
          for (int unsigned n = 0; n < total; n++) begin
            p.kind     = KindBit;
            p.data_bit = (n < FontBits) ? glyph[FontBits-1-n] : 1'b0;
            p.reg_sel  = 1'b0;
            p.last     = (n == total - 1);
            pulse_q.push_back(p);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [KindWidth-1:0] kind, logic data_bit, logic reg_sel,
                               logic last);
      pulse_t got;
      pulse_t want;
      got = '{kind, data_bit, reg_sel, last};
      if (pulse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected pulse kind=%0d data=%b rs=%b last=%b",
                   $realtime, kind, data_bit, reg_sel, last);
        return;
      end
      want = pulse_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch exp k=%0d d=%b rs=%b l=%b, got k=%0d d=%b rs=%b l=%b",
                   $realtime, want.kind, want.data_bit, want.reg_sel, want.last,
                   kind, data_bit, reg_sel, last);
      end
    endfunction

    function int unsigned outstanding();
      return pulse_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          quiet;
  int unsigned sent;

  cgsd_in_if  in_if ();
  cgsd_out_if out_if ();

  glyph_scoreboard sb = new(GlyphCols);

  char_glyph_serial_driver_top #(
    .COLUMNS_PER_GLYPH(GlyphCols)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("Verification failed");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.kind, out_if.data_bit, out_if.register_select, out_if.last);
      out_if.ready <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic send_cmd(input logic [OpWidth-1:0] op, input logic [CharWidth-1:0] code);
    if (!quiet) begin
      while ($urandom_range(99) < IdlePct) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.character <= code;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_cmd(op, code);
    if (op != OpReserved) sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CharWidth-1:0] pick_code();
    string glyph_set;
    glyph_set = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789=.:></!|";
    if ($urandom_range(99) < 85)
      return glyph_set[$urandom_range(glyph_set.len() - 1)];
    return CharWidth'($urandom_range(255));
  endfunction

  initial begin
    logic [CharWidth-1:0] edge_codes[] = '{" ", "A", "Z", "0", "9", "=", ".", ":", ">", "<",
                                           "/", "!", "|", "X", "Y", "a", 8'h00, 8'hFF};
    bit          paused;
    int unsigned nchars;
    in_if.valid     <= 1'b0;
    in_if.operation <= OpOpen;
    in_if.character <= '0;
    rst_ni = 1'b0;
    quiet  = 1'b0;
    paused = 1'b0;
    sent   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(OpOpen, 8'h00);
    foreach (edge_codes[i]) send_cmd(OpChar, edge_codes[i]);
    send_cmd(OpReserved, 8'hFF);
    send_cmd(OpReserved, 8'h00);
    send_cmd(OpClose, 8'hFF);
    drain();

    while (sent < TargetItems) begin
      quiet = (sent >= 90 && sent < 140);
      if (!paused && sent >= 170) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 10) begin
        send_cmd(OpWidth'($urandom_range(3)), CharWidth'($urandom_range(255)));
      end else begin
        send_cmd(OpOpen, CharWidth'($urandom_range(255)));
        nchars = $urandom_range(6, 1);
        repeat (nchars) send_cmd(OpChar, pick_code());
        if ($urandom_range(9) != 0) send_cmd(OpClose, CharWidth'($urandom_range(255)));
      end
    end
    quiet = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
